// ----- sv/b2y420_pkg.sv -----
// Shared types, constants and helper functions of the BGRA to YUV 4:2:0 converter.
package b2y420_pkg;

	localparam int unsigned CH_W          = 8;
	localparam int unsigned DIM_W         = 13;
	localparam int unsigned CPOS_W        = 11;
	localparam int unsigned CFG_IDX_W     = 1;
	localparam int unsigned MAX_WIDTH_DEF  = 4096;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;
	localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	// position of a pixel inside its 2x2 block and the frame
	typedef struct packed {
		logic odd_col;
		logic last_col;
		logic odd_row;
		logic last_row;
	} pos_flags_t;

	// last valid index for a programmed dimension: zero counts as one, large values saturate
	function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] v,
		input int unsigned max_dim);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (32'(v) > max_dim) begin
			res = DIM_W'(max_dim - 1);
		end else begin
			res = v - 1'b1;
		end
		return res;
	endfunction

	// truncating average of four 8-bit samples
	function automatic logic [CH_W-1:0] avg4(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
		input logic [CH_W-1:0] c, input logic [CH_W-1:0] d);
		logic [CH_W+1:0] s;
		s = (CH_W+2)'(a) + (CH_W+2)'(b) + (CH_W+2)'(c) + (CH_W+2)'(d);
		return s[CH_W+1:2];
	endfunction

endpackage

// ----- sv/b2y420_if.sv -----
// Handshake interfaces: pixel input, YUV result output and register write channel.
interface b2y420_pix_if;
	import b2y420_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] red;
	modport source (output valid, blue, green, red, input ready);
	modport sink   (input valid, blue, green, red, output ready);
endinterface

interface b2y420_yuv_if;
	import b2y420_pkg::*;
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   luma;
	logic              chroma_valid;
	logic [CH_W-1:0]   u_value;
	logic [CH_W-1:0]   v_value;
	logic [CPOS_W-1:0] chroma_column;
	logic [CPOS_W-1:0] chroma_row;
	logic              frame_end;
	modport source (output valid, luma, chroma_valid, u_value, v_value, chroma_column,
		chroma_row, frame_end, input ready);
	modport sink   (input valid, luma, chroma_valid, u_value, v_value, chroma_column,
		chroma_row, frame_end, output ready);
endinterface

interface b2y420_cfg_if;
	import b2y420_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/bgra_to_yuv420_converter_top.sv -----
// Top level: BGRA pixel stream to BT.601 limited-range YUV 4:2:0.
//
// Usage:
// - pix_in : one pixel beat (blue, green, red) per accepted handshake, raster order.
// - yuv_out: one result beat per pixel: luma always; U/V with chroma_valid on the
//   pixel that closes a 2x2 block (odd column or last column, odd row or last row).
//   chroma_column/row give the chroma plane position; frame_end flags the last pixel.
//   When chroma_valid is low, u_value, v_value, chroma_column and chroma_row are zero.
// - cfg    : register writes, index 0 = frame_width, index 1 = frame_height. Always
//   ready. Write only while no pixel is in flight. Zero counts as one, values above
//   MAX_WIDTH / MAX_HEIGHT saturate.
// Path: an accepted pixel goes through the input stage, then the output register,
//   before it shows on yuv_out.
// Throughput: one pixel per cycle while yuv_out is not held. The even-row line store
//   is two RAMs (even and odd columns), each read once at the accept edge, so the
//   block never needs a second read per pixel.
// Reset: counters, left pixel and stage valids clear; geometry returns to 1920x1080.
//   The line store is not cleared; odd rows only read what the even row above wrote.
// Stall: while yuv_out is held, the output register keeps its beat and one more
//   pixel can still be taken into the input stage; then pix_in.ready drops.
module bgra_to_yuv420_converter_top #(
	parameter int unsigned MAX_WIDTH  = b2y420_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = b2y420_pkg::MAX_HEIGHT_DEF
) (
	input logic                clk,
	input logic                arst_n,
	b2y420_pix_if.sink         pix_in,
	b2y420_yuv_if.source       yuv_out,
	b2y420_cfg_if.sink         cfg
);
	import b2y420_pkg::*;

	localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned AW    = (CW > 1) ? CW - 1 : 1;
	localparam int unsigned DEPTH = 1 << AW;

	localparam logic [DIM_W-1:0] WLAST_RST = dim_last(RESET_WIDTH, MAX_WIDTH);
	localparam logic [DIM_W-1:0] HLAST_RST = dim_last(RESET_HEIGHT, MAX_HEIGHT);

	// geometry, held as last column / last row index
	logic [CW-1:0] wlast_q;
	logic [RW-1:0] hlast_q;

	// raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	pixel_t        left_q;

	// line store, split by column parity; entry k holds column 2k / 2k+1
	pixel_t mem_even [DEPTH];
	pixel_t mem_odd  [DEPTH];

	// input stage
	logic              valid_s1;
	pixel_t            pix_s1;
	pixel_t            left_s1;
	pixel_t            rd_even_s1;
	pixel_t            rd_odd_s1;
	pos_flags_t        pos_s1;
	logic [CPOS_W-1:0] ccol_s1;
	logic [CPOS_W-1:0] crow_s1;

	// output register
	logic              valid_s2;
	logic [CH_W-1:0]   luma_s2;
	logic              cvalid_s2;
	logic [CH_W-1:0]   u_s2;
	logic [CH_W-1:0]   v_s2;
	logic [CPOS_W-1:0] ccol_s2;
	logic [CPOS_W-1:0] crow_s2;
	logic              fend_s2;

	logic       accept;
	logic       adv;
	pixel_t     pix_in_w;
	pos_flags_t pos_in;
	logic [AW-1:0] addr;

	// ---------------------------------------------------------------
	// Handshake: the output register frees whenever it is empty or taken
	// ---------------------------------------------------------------
	assign adv          = !valid_s2 || yuv_out.ready;
	assign pix_in.ready = !valid_s1 || adv;
	assign accept       = pix_in.valid && pix_in.ready;
	assign cfg.ready    = 1'b1;

	assign pix_in_w = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};
	assign addr     = AW'(col_q >> 1);

	assign pos_in.odd_col  = col_q[0];
	assign pos_in.last_col = (col_q >= wlast_q);
	assign pos_in.odd_row  = row_q[0];
	assign pos_in.last_row = (row_q >= hlast_q);

	// ---------------------------------------------------------------
	// Register writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(WLAST_RST);
			hlast_q <= RW'(HLAST_RST);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  wlast_q <= CW'(dim_last(cfg.data, MAX_WIDTH));
				REG_FRAME_HEIGHT: hlast_q <= RW'(dim_last(cfg.data, MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Raster counters and left neighbor, advanced per accepted beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= pix_in_w;
			if (pos_in.last_col) begin
				col_q <= '0;
				row_q <= pos_in.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line store: even rows write, odd rows use the read data; both RAMs are read every accepted beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept && !pos_in.odd_row && !pos_in.odd_col) begin
			mem_even[addr] <= pix_in_w;
		end
		if (accept) begin
			rd_even_s1 <= mem_even[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pos_in.odd_row && pos_in.odd_col) begin
			mem_odd[addr] <= pix_in_w;
		end
		if (accept) begin
			rd_odd_s1 <= mem_odd[addr];
		end
	end

	// ---------------------------------------------------------------
	// Input stage
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_in_w;
			left_s1 <= left_q;
			pos_s1  <= pos_in;
			ccol_s1 <= CPOS_W'(col_q >> 1);
			crow_s1 <= CPOS_W'(row_q >> 1);
		end
	end

	// ---------------------------------------------------------------
	// Conversion: block corner selection, averages, constant products
	// ---------------------------------------------------------------
	pixel_t p0, p1, p2, p3;
	logic   cvalid;

	assign cvalid = (pos_s1.odd_col || pos_s1.last_col) && (pos_s1.odd_row || pos_s1.last_row);

	always_comb begin
		p0 = pix_s1;
		p1 = pix_s1;
		p2 = pix_s1;
		p3 = pix_s1;
		if (pos_s1.odd_row) begin
			if (pos_s1.odd_col) begin
				p0 = rd_even_s1;
				p1 = rd_odd_s1;
				p2 = left_s1;
			end else begin
				// odd width: last column repeats itself
				p0 = rd_even_s1;
				p1 = rd_even_s1;
			end
		end else begin
			// odd height: last row paired with itself
			p0 = pos_s1.odd_col ? left_s1 : pix_s1;
			p2 = p0;
		end
	end

	logic [16:0]     r17, g17, b17, y_sum;
	logic [CH_W-1:0] luma;
	logic [CH_W-1:0] avg_r, avg_g, avg_b;
	logic signed [17:0] ar, ag, ab, u_sum, v_sum;
	logic [CH_W-1:0] u_val, v_val;

	assign r17   = 17'(pix_s1.red);
	assign g17   = 17'(pix_s1.green);
	assign b17   = 17'(pix_s1.blue);
	assign y_sum = 17'd66 * r17 + 17'd129 * g17 + 17'd25 * b17 + 17'd128;
	assign luma  = y_sum[15:8] + 8'd16;

	assign avg_r = avg4(p0.red, p1.red, p2.red, p3.red);
	assign avg_g = avg4(p0.green, p1.green, p2.green, p3.green);
	assign avg_b = avg4(p0.blue, p1.blue, p2.blue, p3.blue);

	assign ar = $signed({10'd0, avg_r});
	assign ag = $signed({10'd0, avg_g});
	assign ab = $signed({10'd0, avg_b});

	assign u_sum = -18'sd38 * ar - 18'sd74 * ag + 18'sd112 * ab + 18'sd128;
	assign v_sum = 18'sd112 * ar - 18'sd94 * ag - 18'sd18 * ab + 18'sd128;

	// (x >>> 8) + 128 modulo 256 is bits 15:8 with the top bit flipped
	assign u_val = {~u_sum[15], u_sum[14:8]};
	assign v_val = {~v_sum[15], v_sum[14:8]};

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			luma_s2   <= luma;
			cvalid_s2 <= cvalid;
			u_s2      <= cvalid ? u_val : '0;
			v_s2      <= cvalid ? v_val : '0;
			ccol_s2   <= cvalid ? ccol_s1 : '0;
			crow_s2   <= cvalid ? crow_s1 : '0;
			fend_s2   <= pos_s1.last_col && pos_s1.last_row;
		end
	end

	assign yuv_out.valid         = valid_s2;
	assign yuv_out.luma          = luma_s2;
	assign yuv_out.chroma_valid  = cvalid_s2;
	assign yuv_out.u_value       = u_s2;
	assign yuv_out.v_value       = v_s2;
	assign yuv_out.chroma_column = ccol_s2;
	assign yuv_out.chroma_row    = crow_s2;
	assign yuv_out.frame_end     = fend_s2;

endmodule

// ----- sv/b2y420_checker.sv -----
// Port-level assertions for the converter top, attached by bind.
module b2y420_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [b2y420_pkg::CH_W-1:0]   luma,
	input logic                          chroma_valid,
	input logic [b2y420_pkg::CH_W-1:0]   u_value,
	input logic [b2y420_pkg::CH_W-1:0]   v_value,
	input logic [b2y420_pkg::CPOS_W-1:0] chroma_column,
	input logic [b2y420_pkg::CPOS_W-1:0] chroma_row
);
	import b2y420_pkg::*;

	// a stalled result beat holds valid, luma, U/V and chroma_valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(luma) && $stable(u_value)
			&& $stable(v_value) && $stable(chroma_valid))
		else $error("result beat changed while stalled");

	// luma stays in limited range
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> luma >= 8'd16 && luma <= 8'd235)
		else $error("luma out of range");

	// chroma stays in limited range on block beats
	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chroma_valid |-> u_value >= 8'd16 && u_value <= 8'd240
			&& v_value >= 8'd16 && v_value <= 8'd240)
		else $error("chroma out of range");

	// non-block beats carry zero chroma fields
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> u_value == '0 && v_value == '0
			&& chroma_column == '0 && chroma_row == '0)
		else $error("chroma fields set without a completed block");

endmodule

bind bgra_to_yuv420_converter_top b2y420_checker u_b2y420_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (yuv_out.valid),
	.out_ready     (yuv_out.ready),
	.luma          (yuv_out.luma),
	.chroma_valid  (yuv_out.chroma_valid),
	.u_value       (yuv_out.u_value),
	.v_value       (yuv_out.v_value),
	.chroma_column (yuv_out.chroma_column),
	.chroma_row    (yuv_out.chroma_row)
);
